[sv/insertion_sorter_assert.svh]
// Assertion macros shared by the sorter RTL.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// The condition must never hold outside reset.
`define ISORT_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("sorter check failed");

// When the antecedent holds, the consequent must hold on the next cycle.
`define ISORT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorter check failed");

`endif

[sv/isort_pkg.sv]
package isort_pkg;

   // Width of one sorted element.
   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Control that the top level broadcasts to every cell.
   typedef struct packed {
      logic insert;   // a new value is placed into the chain this cycle
      logic shift;    // every cell takes its right neighbor's value
   } cell_ctl_type;

endpackage

[sv/insertion_sorter.sv]
// The first sorted result is offered in the cycle after the transaction marked last.
// While a set is gathered, one input transaction is taken per cycle; the stored values then
// drain one per accepted result, and no input is taken meanwhile.
// The insertion point is found by one compare in each cell of the chain, all in parallel.
// Reset (synchronous, active high) clears the fill count, the drain state and the overflow
// flag; cell contents are not reset and are only read below the fill count.
module insertion_sorter #(
   parameter int MAX_ELEMS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  isort_pkg::value_type req_tdata,   // [31:0] value
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output isort_pkg::value_type rsp_tdata,   // [31:0] sorted_value
   output logic                 rsp_tlast,
   output logic                 rsp_tuser    // [0] overflow
);

   `include "insertion_sorter_assert.svh"

   localparam int CNT_W = $clog2(MAX_ELEMS + 1);

   logic [CNT_W-1:0]       fill_count_ff;
   logic [CNT_W-1:0]       fill_count_in;
   logic                   drain_ff;
   logic                   drain_in;
   logic                   dropped_ff;
   logic                   dropped_in;
   logic                   req_acc;
   logic                   rsp_acc;
   logic                   full;
   isort_pkg::cell_ctl_type ctl;
   isort_pkg::value_type   cell_value [MAX_ELEMS];
   logic                   cell_occupy [MAX_ELEMS];

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign full    = (fill_count_ff == CNT_W'(MAX_ELEMS));

   // Broadcast control for the chain.
   assign ctl.insert = req_acc && !full;
   assign ctl.shift  = rsp_acc;

   // Row of cells, each linked to both neighbors.
   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      isort_pkg::value_type left_value;
      logic                 left_occupy;
      isort_pkg::value_type right_value;
      logic                 valid;

      assign valid = (CNT_W'(i) < fill_count_ff);

      if (i == 0) begin : g_first
         assign left_value  = req_tdata;
         assign left_occupy = 1'b0;
      end else begin : g_inner
         assign left_value  = cell_value[i-1];
         assign left_occupy = cell_occupy[i-1];
      end

      if (i == MAX_ELEMS - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .valid       (valid),
         .new_value   (req_tdata),
         .left_value  (left_value),
         .left_occupy (left_occupy),
         .right_value (right_value),
         .value       (cell_value[i]),
         .occupy      (cell_occupy[i])
      );
   end

   // Fill count, drain state and overflow flag.
   always_comb begin
      fill_count_in = fill_count_ff;
      drain_in      = drain_ff;
      dropped_in    = dropped_ff;
      if (req_acc) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            fill_count_in = fill_count_ff + CNT_W'(1);
         end
         drain_in = req_tlast;
      end else if (rsp_acc) begin
         fill_count_in = fill_count_ff - CNT_W'(1);
         if (fill_count_ff == CNT_W'(1)) begin
            drain_in   = 1'b0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         drain_ff      <= 1'b0;
         dropped_ff    <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         drain_ff      <= drain_in;
         dropped_ff    <= dropped_in;
      end
   end

   // Results leave from the head cell of the chain.
   assign req_tready = !drain_ff;
   assign rsp_tvalid = drain_ff;
   assign rsp_tdata  = cell_value[0];
   assign rsp_tlast  = (fill_count_ff == CNT_W'(1));
   assign rsp_tuser  = dropped_ff;

   // Gathering and draining never overlap.
   `ISORT_ASSERT_NEVER(a_no_overlap, req_tready && rsp_tvalid)
   // The fill count stays within the chain.
   `ISORT_ASSERT_NEVER(a_fill_bound, fill_count_ff > CNT_W'(MAX_ELEMS))
   // A transaction marked last starts the drain at once.
   `ISORT_ASSERT_NEXT(a_drain_start, req_acc && req_tlast, rsp_tvalid && fill_count_ff != '0)
   // The final result leaves the block empty and the flag cleared.
   `ISORT_ASSERT_NEXT(a_drain_end, rsp_acc && rsp_tlast,
                      !rsp_tvalid && fill_count_ff == '0 && !dropped_ff)

endmodule

[sv/isort_cell.sv]
module isort_cell (
   input  logic                  clock,
   input  isort_pkg::cell_ctl_type ctl,
   input  logic                  valid,
   input  isort_pkg::value_type  new_value,
   input  isort_pkg::value_type  left_value,
   input  logic                  left_occupy,
   input  isort_pkg::value_type  right_value,
   output isort_pkg::value_type  value,
   output logic                  occupy
);

   isort_pkg::value_type value_ff;
   isort_pkg::value_type value_in;

   // The cell lies at or beyond the insertion point when it is empty or
   // holds a strictly greater value, so equal values keep arrival order.
   assign occupy = !valid || (value_ff > new_value);

   // Shift toward the output while draining, shift up on an insertion.
   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = right_value;
      end else if (ctl.insert && occupy) begin
         value_in = left_occupy ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[tb/sv/insertion_sorter_test.sv]
module insertion_sorter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 64;
   localparam int FEED_RANDOM = 280;
   localparam int SETTLE_CYCLES = 20;
   localparam isort_pkg::value_type MOST_NEGATIVE = 32'sh8000_0000;
   localparam isort_pkg::value_type MOST_POSITIVE = 32'sh7fff_ffff;

   // One element of a set on its way into the sorter.
   typedef struct {
      isort_pkg::value_type value;
      logic                 last;
   } set_element_type;

   // One element of a sorted run as the sorter should emit it.
   typedef struct {
      isort_pkg::value_type value;
      logic                 last;
      logic                 overflow;
   } sorted_entry_type;

   // Shapes of the random values inside one set.
   typedef enum int {
      MIX_WIDE,
      MIX_CLUSTERED,
      MIX_EDGES
   } value_mix_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   isort_pkg::value_type req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   isort_pkg::value_type rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;

   set_element_type      element_feed[$];
   sorted_entry_type     sorted_expect[$];

   // Predicted contents of the sorter, kept in ascending order.
   isort_pkg::value_type held_values[$];
   logic                 held_dropped = 1'b0;

   int                   fault_count = 0;
   int                   feed_wait = 0;
   bit                   feed_steady = 1'b0;
   int                   drain_wait = 0;
   bit                   drain_steady = 1'b0;
   int                   drain_draw;
   set_element_type      next_element;

   insertion_sorter #(
      .MAX_ELEMS(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle time before the next transaction; a steady side never idles.
   function automatic int pick_wait(input bit steady);
      if (steady) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic isort_pkg::value_type pick_value(input value_mix_type mix);
      case (mix)
         MIX_CLUSTERED: return isort_pkg::value_type'(int'($urandom_range(0, 8)) - 4);
         MIX_EDGES: begin
            case ($urandom_range(0, 6))
               0: return MOST_NEGATIVE;
               1: return MOST_POSITIVE;
               2: return MOST_NEGATIVE + 1;
               3: return MOST_POSITIVE - 1;
               4: return '0;
               5: return '1;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_element(input isort_pkg::value_type value, input logic last);
      set_element_type elem;
      elem.value = value;
      elem.last = last;
      element_feed = {element_feed, elem};
   endfunction

   function automatic void add_set(input int count, input value_mix_type mix);
      for (int i = 0; i < count; i++) add_element(pick_value(mix), i == count - 1);
   endfunction

   // Insert one accepted value into the predicted store; a last element releases
   // the whole store in ascending order and empties it.
   function automatic void absorb_element(input isort_pkg::value_type value,
                                          input logic last);
      int pos;
      sorted_entry_type entry;
      if (held_values.size() >= CAPACITY) begin
         held_dropped = 1'b1;
      end else begin
         pos = held_values.size();
         while (pos > 0 && held_values[pos-1] > value) pos--;
         held_values.insert(pos, value);
      end
      if (last) begin
         foreach (held_values[k]) begin
            entry.value = held_values[k];
            entry.last = (k == held_values.size() - 1);
            entry.overflow = held_dropped;
            sorted_expect = {sorted_expect, entry};
         end
         held_values.delete();
         held_dropped = 1'b0;
      end
   endfunction

   // Input driver: waits its drawn idle time, then offers the next element.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         feed_wait <= pick_wait(feed_steady);
      end else if (!req_tvalid || req_tready) begin
         if (feed_wait != 0) begin
            req_tvalid <= 1'b0;
            feed_wait <= feed_wait - 1;
         end else if (element_feed.size() != 0) begin
            next_element = element_feed.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_element.value;
            req_tlast <= next_element.last;
            if ($urandom_range(0, 39) == 0) feed_steady <= !feed_steady;
            feed_wait <= pick_wait(feed_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: after each transaction, hold ready low for a drawn time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         drain_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 39) == 0) drain_steady <= !drain_steady;
         drain_draw = pick_wait(drain_steady);
         drain_wait <= drain_draw;
         rsp_tready <= (drain_draw == 0);
      end else if (drain_wait != 0) begin
         drain_wait <= drain_wait - 1;
         rsp_tready <= (drain_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted input, check each accepted result.
   always @(posedge clock) begin
      sorted_entry_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) absorb_element(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_expect.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%t: unexpected result value=%0d last=%b overflow=%b",
                           $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last ||
                   rsp_tuser !== want.overflow) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%t: mismatch expected %0d/%b/%b, got %0d/%b/%b",
                              $realtime, want.value, want.last, want.overflow,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int queued;
      value_mix_type mix;
      int span;

      // A set of one element.
      add_element('0, 1'b1);
      // Both extremes, with repeats, in one set.
      add_element(MOST_POSITIVE, 1'b0);
      add_element(MOST_NEGATIVE, 1'b0);
      add_element('1, 1'b0);
      add_element('0, 1'b0);
      add_element(1, 1'b0);
      add_element(MOST_NEGATIVE, 1'b0);
      add_element(MOST_POSITIVE, 1'b1);
      // Falling values: every new element goes to the bottom of the store.
      for (int i = 4; i >= 0; i--) add_element(i * 1000 - 2000, i == 0);
      // Rising values: nothing shifts.
      for (int i = 0; i < 5; i++) add_element(i * 7 - 14, i == 4);
      // Exactly full, then past capacity with the last two elements dropped,
      // then a short set that must show the overflow flag cleared again.
      add_set(CAPACITY, MIX_WIDE);
      add_set(CAPACITY + 2, MIX_CLUSTERED);
      add_set(3, MIX_EDGES);

      // Random sets: mostly short, now and then around or beyond capacity.
      queued = 0;
      while (queued < FEED_RANDOM) begin
         if ($urandom_range(0, 19) == 0) span = $urandom_range(CAPACITY - 4, CAPACITY + 6);
         else span = $urandom_range(1, 12);
         mix = value_mix_type'($urandom_range(0, 2));
         add_set(span, mix);
         queued += span;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (element_feed.size() != 0 || req_tvalid) @(posedge clock);
      while (sorted_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("insertion_sorter verification clean");
      end else begin
         $display("insertion_sorter verification failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("insertion_sorter verification failed");
      $finish;
   end

endmodule
